### hw/rtl/slda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slda_pkg: shared types and constants for the single-lane direction arbiter
// Holds the request and configuration codes, the arbiter state record and the
// result record that travels on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

package slda_pkg;

  // Request kinds carried in req_type.
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_EXIT    = 1'b1;

  // Side and direction codes.
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // Configuration register indexes.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CAPACITY     = 1'd0;
  localparam cfg_idx_t CFG_STARVE_LIMIT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [7:0] CAPACITY_RESET     = 8'd10;
  localparam logic [7:0] STARVE_LIMIT_RESET = 8'd5;

  // Waiting counts never pass the smaller of MAX_WAITING and 255.
  localparam int unsigned MAX_WAITING = 255;
  localparam logic [7:0]  WAIT_CAP    = (MAX_WAITING < 255) ? 8'(MAX_WAITING) : 8'd255;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0]      occupancy;
    logic            direction;
    logic [1:0][7:0] waiting;
    logic [1:0][7:0] starve;
    logic [1:0]      blocked;
  } state_t;

  typedef struct packed {
    logic       granted;
    logic       granted_side;
    logic       from_queue;
    logic       rejected;
    logic [7:0] occupancy_now;
    logic       path_direction;
    logic [7:0] left_waiting_now;
    logic [7:0] right_waiting_now;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/slda_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slda_if: channel interfaces of the single-lane direction arbiter
// The request channel carries one arrival or exit per word; the result channel
// carries the outcome of one request per word. Both use valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface slda_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic side;

  modport source (output valid, output req_type, output side, input ready);
  modport sink   (input valid, input req_type, input side, output ready);
endinterface

interface slda_out_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic       granted_side;
  logic       from_queue;
  logic       rejected;
  logic [7:0] occupancy_now;
  logic       path_direction;
  logic [7:0] left_waiting_now;
  logic [7:0] right_waiting_now;

  modport source (
    output valid, output granted, output granted_side, output from_queue,
    output rejected, output occupancy_now, output path_direction,
    output left_waiting_now, output right_waiting_now, input ready
  );
  modport sink (
    input valid, input granted, input granted_side, input from_queue,
    input rejected, input occupancy_now, input path_direction,
    input left_waiting_now, input right_waiting_now, output ready
  );
endinterface

`default_nettype wire

### hw/rtl/single_lane_direction_arbiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_lane_direction_arbiter_top: one-lane shared path arbiter
// Admits arrivals onto a one-direction path, queues them by count when they
// cannot enter, blocks a side that starves the other, and wakes at most one
// waiter on each exit.
// ----------------------------------------------------------------------------
// Flow: an accepted word lands in the request register, and its result is
//   registered in the result register when the stage fires and then offered.
// Throughput: one request word per cycle while the result channel is not
//   stalled; state updates as each word fires, so no word waits on it.
// Reset (synchronous, rst_n low): path empty, direction left, all waiting and
//   starvation counts and block flags zero, capacity 10, starvation limit 5,
//   both channel stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module single_lane_direction_arbiter_top
  import slda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_addr,
  input  logic [7:0] cfg_wdata,
  slda_in_if.sink    in_chan,
  slda_out_if.source out_chan
);

  // Configuration registers.
  logic [7:0] capacity_r;
  logic [7:0] starve_limit_r;

  // Request stage: one word held until the result register can take its result.
  logic in_vld_r;
  logic in_req_type_r;
  logic in_side_r;

  // Arbiter state and the result stage.
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t out_res_r;
  logic    out_vld_r;

  // The request stage fires when the result register is empty or being drained.
  logic fire;
  assign fire       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || fire;

  // Working signals of the step logic.
  logic       cur_side;
  logic       oth_side;
  logic [7:0] occ_after_exit;
  logic       wake_vld;
  logic       wake_side;

  // One request against the current state. An arrival on an empty path first
  // turns the path toward its own side. An exit frees a slot, charges the
  // current side with one starvation tick if the other side waits, blocks a side
  // whose count reaches the limit, and then wakes at most one waiter: the other
  // side first when the path has drained, else the current side.
  always_comb begin
    st_nxt         = st_r;
    res_nxt        = '0;
    cur_side       = st_r.direction;
    oth_side       = ~st_r.direction;
    occ_after_exit = (st_r.occupancy == '0) ? '0 : st_r.occupancy - 8'd1;
    wake_vld       = 1'b0;
    wake_side      = SIDE_LEFT;

    if (in_req_type_r == REQ_ARRIVAL) begin
      if (st_r.occupancy == '0) begin
        st_nxt.direction = in_side_r;
      end
      if (st_r.occupancy < capacity_r && st_nxt.direction == in_side_r &&
          !st_r.blocked[in_side_r]) begin
        st_nxt.occupancy     = st_r.occupancy + 8'd1;
        res_nxt.granted      = 1'b1;
        res_nxt.granted_side = in_side_r;
      end else if (st_r.waiting[in_side_r] >= WAIT_CAP) begin
        res_nxt.rejected = 1'b1;
      end else begin
        st_nxt.waiting[in_side_r] = st_r.waiting[in_side_r] + 8'd1;
      end
    end else begin
      st_nxt.occupancy = occ_after_exit;
      if (st_r.waiting[oth_side] != '0 && st_r.starve[cur_side] != COUNT_MAX) begin
        st_nxt.starve[cur_side] = st_r.starve[cur_side] + 8'd1;
      end
      if (st_nxt.starve[SIDE_LEFT] >= starve_limit_r) begin
        st_nxt.blocked[SIDE_LEFT] = 1'b1;
      end
      if (st_nxt.starve[SIDE_RIGHT] >= starve_limit_r) begin
        st_nxt.blocked[SIDE_RIGHT] = 1'b1;
      end

      if (occ_after_exit == '0 && st_r.waiting[oth_side] != '0) begin
        wake_vld  = 1'b1;
        wake_side = oth_side;
      end else if (st_r.waiting[cur_side] != '0) begin
        wake_vld  = 1'b1;
        wake_side = cur_side;
      end

      if (wake_vld) begin
        // A waiter woken onto an empty path takes the direction and lifts
        // the penalty on the opposite side.
        if (occ_after_exit == '0) begin
          st_nxt.direction          = wake_side;
          st_nxt.starve[~wake_side]  = '0;
          st_nxt.blocked[~wake_side] = 1'b0;
        end
        if (occ_after_exit < capacity_r && st_nxt.direction == wake_side &&
            !st_nxt.blocked[wake_side]) begin
          st_nxt.waiting[wake_side] = st_r.waiting[wake_side] - 8'd1;
          st_nxt.occupancy          = occ_after_exit + 8'd1;
          res_nxt.granted           = 1'b1;
          res_nxt.granted_side      = wake_side;
          res_nxt.from_queue        = 1'b1;
        end
      end
    end

    res_nxt.occupancy_now     = st_nxt.occupancy;
    res_nxt.path_direction    = st_nxt.direction;
    res_nxt.left_waiting_now  = st_nxt.waiting[SIDE_LEFT];
    res_nxt.right_waiting_now = st_nxt.waiting[SIDE_RIGHT];
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r     <= CAPACITY_RESET;
      starve_limit_r <= STARVE_LIMIT_RESET;
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      st_r           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CAPACITY:     capacity_r     <= cfg_wdata;
          CFG_STARVE_LIMIT: starve_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_req_type_r <= in_chan.req_type;
      in_side_r     <= in_chan.side;
    end
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid             = out_vld_r;
  assign out_chan.granted           = out_res_r.granted;
  assign out_chan.granted_side      = out_res_r.granted_side;
  assign out_chan.from_queue        = out_res_r.from_queue;
  assign out_chan.rejected          = out_res_r.rejected;
  assign out_chan.occupancy_now     = out_res_r.occupancy_now;
  assign out_chan.path_direction    = out_res_r.path_direction;
  assign out_chan.left_waiting_now  = out_res_r.left_waiting_now;
  assign out_chan.right_waiting_now = out_res_r.right_waiting_now;

endmodule

`default_nettype wire

### hw/rtl/slda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slda_checker: port-level checks for the single-lane direction arbiter
// Watches the result channel and flags outcomes that the arbiter can never
// produce, plus the stall rule of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module slda_checker
  import slda_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       granted,
  input logic       granted_side,
  input logic       from_queue,
  input logic       rejected,
  input logic [7:0] occupancy_now,
  input logic       path_direction,
  input logic [7:0] left_waiting_now,
  input logic [7:0] right_waiting_now
);

  // Nothing comes out in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // An admitted item is on the path and the path points its way.
  a_grant_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && granted |-> occupancy_now != 8'd0 && path_direction == granted_side)
    else $error("grant does not match path state");

  // A woken waiter is only reported together with a grant, and never with a drop.
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (from_queue || rejected) |-> (from_queue == granted) && !(granted && rejected))
    else $error("queue and reject flags inconsistent");

  // A dropped arrival means one side's waiting count sits at its limit.
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rejected |-> left_waiting_now == WAIT_CAP || right_waiting_now == WAIT_CAP)
    else $error("arrival dropped while no waiting count is full");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(granted_side) &&
      $stable(occupancy_now) && $stable(left_waiting_now) && $stable(right_waiting_now))
    else $error("result word changed while stalled");

endmodule

bind single_lane_direction_arbiter_top slda_checker u_slda_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .granted           (out_chan.granted),
  .granted_side      (out_chan.granted_side),
  .from_queue        (out_chan.from_queue),
  .rejected          (out_chan.rejected),
  .occupancy_now     (out_chan.occupancy_now),
  .path_direction    (out_chan.path_direction),
  .left_waiting_now  (out_chan.left_waiting_now),
  .right_waiting_now (out_chan.right_waiting_now)
);

`default_nettype wire

### bench/single_lane_direction_arbiter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_lane_direction_arbiter_top_tb: self-checking bench for the arbiter
// Sends arrival and exit words through several capacity and starvation
// settings, predicts every result word with a behavioral copy of the path
// state, and compares each result field by field with random stalls on both
// channels.
// ----------------------------------------------------------------------------

module single_lane_direction_arbiter_top_tb;
  import slda_pkg::*;

  // The path state is mirrored here. Each accepted request word updates the
  // mirror and queues the result word that the block must produce for it.
  class path_scoreboard;
    bit [7:0] capacity;
    bit [7:0] starve_limit;
    bit [7:0] occupancy;
    bit       direction;
    bit [7:0] waiting [2];
    bit [7:0] starve [2];
    bit       blocked [2];
    result_t  expected_outcomes [$];
    int       errors;

    function new();
      capacity     = CAPACITY_RESET;
      starve_limit = STARVE_LIMIT_RESET;
      occupancy    = '0;
      direction    = SIDE_LEFT;
      for (int i = 0; i < 2; i++) begin
        waiting[i] = '0;
        starve[i]  = '0;
        blocked[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [7:0] val);
      if (idx == CFG_CAPACITY) begin
        capacity = val;
      end else begin
        starve_limit = val;
      end
    endfunction

    function bit may_enter(bit s);
      return occupancy < capacity && direction == s && !blocked[s];
    endfunction

    // Advances the mirror by one request and queues the expected result.
    function void note_request(bit kind, bit s);
      result_t r;
      bit      cur;
      bit      oth;
      bit      wake_any;
      bit      w;
      r = '0;
      if (kind == REQ_ARRIVAL) begin
        // An arrival on an empty path turns the path toward its own side.
        if (occupancy == 0) direction = s;
        if (may_enter(s)) begin
          occupancy++;
          r.granted      = 1'b1;
          r.granted_side = s;
        end else if (waiting[s] >= WAIT_CAP) begin
          r.rejected = 1'b1;
        end else begin
          waiting[s]++;
        end
      end else begin
        cur      = direction;
        oth      = ~cur;
        wake_any = 1'b0;
        w        = SIDE_LEFT;
        if (occupancy != 0) occupancy--;
        if (waiting[oth] != 0 && starve[cur] != COUNT_MAX) starve[cur]++;
        for (int i = 0; i < 2; i++) begin
          if (starve[i] >= starve_limit) blocked[i] = 1'b1;
        end
        // The opposite side is woken first only once the path has emptied.
        if (occupancy == 0 && waiting[oth] != 0) begin
          wake_any = 1'b1;
          w        = oth;
        end else if (waiting[cur] != 0) begin
          wake_any = 1'b1;
          w        = cur;
        end
        if (wake_any) begin
          if (occupancy == 0) begin
            direction  = w;
            starve[~w]  = '0;
            blocked[~w] = 1'b0;
          end
          if (may_enter(w)) begin
            waiting[w]--;
            occupancy++;
            r.granted      = 1'b1;
            r.granted_side = w;
            r.from_queue   = 1'b1;
          end
        end
      end
      r.occupancy_now     = occupancy;
      r.path_direction    = direction;
      r.left_waiting_now  = waiting[SIDE_LEFT];
      r.right_waiting_now = waiting[SIDE_RIGHT];
      expected_outcomes.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_outcomes.pop_front();
      compare_field("granted", 8'(want.granted), 8'(got.granted));
      compare_field("granted_side", 8'(want.granted_side), 8'(got.granted_side));
      compare_field("from_queue", 8'(want.from_queue), 8'(got.from_queue));
      compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
      compare_field("occupancy_now", want.occupancy_now, got.occupancy_now);
      compare_field("path_direction", 8'(want.path_direction), 8'(got.path_direction));
      compare_field("left_waiting_now", want.left_waiting_now, got.left_waiting_now);
      compare_field("right_waiting_now", want.right_waiting_now, got.right_waiting_now);
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction
  endclass

  // The slowest correct word costs a sender gap, a receiver stall and its pass
  // through the request and result registers; about 500 words fit far below this.
  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  cfg_idx_t   cfg_addr;
  logic [7:0] cfg_wdata;

  slda_in_if  in_if ();
  slda_out_if out_if ();

  path_scoreboard board;

  // Percentage chance that either side starts an idle burst on a given word
  // or cycle. Zero turns idling off for a whole phase.
  int idle_pct;
  int stall_cnt = 0;
  int cycles = 0;

  single_lane_direction_arbiter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  always #1 clk = ~clk;

  // The receiver stalls in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= stall_cnt - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_if.ready <= 1'b0;
      stall_cnt    <= $urandom_range(0, 9);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // One monitor watches both channels, so a request word is always noted
  // before any result word that could belong to it is checked.
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.granted           = out_if.granted;
        got.granted_side      = out_if.granted_side;
        got.from_queue        = out_if.from_queue;
        got.rejected          = out_if.rejected;
        got.occupancy_now     = out_if.occupancy_now;
        got.path_direction    = out_if.path_direction;
        got.left_waiting_now  = out_if.left_waiting_now;
        got.right_waiting_now = out_if.right_waiting_now;
        board.check_result(got);
      end
      if (in_if.valid && in_if.ready) begin
        board.note_request(in_if.req_type, in_if.side);
      end
    end
  end

  // Hard stop in case the block hangs on either handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one request word and returns at the edge that accepts it. The
  // caller is always at a rising edge, so valid gets a single update per step.
  task automatic send_word(bit kind, bit s);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= kind;
    in_if.side     <= s;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic arrive(bit s);
    send_word(REQ_ARRIVAL, s);
  endtask

  task automatic leave();
    send_word(REQ_EXIT, 1'($urandom_range(0, 1)));
  endtask

  // Random traffic: exit_pct sets how often a word is an exit, left_pct how
  // often an arrival comes from the left.
  task automatic random_traffic(int count, int exit_pct, int left_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < exit_pct) begin
        leave();
      end else begin
        arrive($urandom_range(0, 99) >= left_pct);
      end
    end
  endtask

  // Stops the request channel and waits until every result word is back, so
  // the block is idle before its registers change. The first edge lets the
  // monitor note a word accepted at the edge the caller returned on.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Writes both registers, capacity first and then the starvation limit.
  task automatic write_config(bit [7:0] cap, bit [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_addr  <= CFG_STARVE_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(CFG_CAPACITY, cap);
    board.set_reg(CFG_STARVE_LIMIT, limit);
  endtask

  task automatic reconfigure(bit [7:0] cap, bit [7:0] limit, int pct);
    drain();
    write_config(cap, limit);
    idle_pct = pct;
  endtask

  initial begin
    bit flood_side;
    board          = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = CFG_CAPACITY;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.req_type = REQ_ARRIVAL;
    in_if.side     = SIDE_LEFT;
    idle_pct       = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings (capacity 10, limit 5). It
    // starts with an exit from an empty path, lets the path turn right on an
    // arrival, wakes a left waiter once the path empties, and then keeps left
    // traffic flowing while right waits until the left side becomes blocked
    // and a further left arrival has to queue.
    idle_pct = 15;
    leave();
    arrive(SIDE_RIGHT);
    arrive(SIDE_LEFT);
    arrive(SIDE_RIGHT);
    arrive(SIDE_RIGHT);
    leave();
    leave();
    leave();
    arrive(SIDE_RIGHT);
    arrive(SIDE_RIGHT);
    arrive(SIDE_LEFT);
    arrive(SIDE_LEFT);
    for (int i = 0; i < 5; i++) begin
      leave();
      arrive(SIDE_LEFT);
    end
    leave();
    leave();
    leave();

    // Smallest capacity and limit: every exit while the other side waits
    // blocks the current side at once.
    reconfigure(8'd1, 8'd1, 20);
    random_traffic(40, 45, 50);

    // Largest capacity and limit: the path rarely fills and rarely blocks.
    reconfigure(8'd255, 8'd255, 10);
    random_traffic(40, 35, 50);

    // Flood one side behind a single-item path until its waiting count is
    // full and further arrivals are dropped, then let exits wake waiters.
    reconfigure(8'd1, 8'd255, 0);
    flood_side = 1'($urandom_range(0, 1));
    for (int i = 0; i < 262; i++) begin
      arrive(flood_side);
    end
    idle_pct = 15;
    random_traffic(30, 60, 50);

    // Small capacities and limits with uneven traffic keep the path turning.
    reconfigure(8'($urandom_range(2, 8)), 8'($urandom_range(2, 6)), 25);
    random_traffic(35, 50, 70);

    reconfigure(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 10);
    random_traffic(35, 45, 30);

    // Last stretch runs without any idling on either side.
    reconfigure(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)), 0);
    random_traffic(30, 50, 50);

    drain();
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/slda_pkg.sv
hw/rtl/slda_if.sv
hw/rtl/single_lane_direction_arbiter_top.sv
hw/rtl/slda_checker.sv
bench/single_lane_direction_arbiter_top_tb.sv
